[rtl/sync_length_crc16_frame_receiver_defines.svh]
// assertion macros, clocked on clk_i and quiet while rst_ni is low
`ifndef SYNC_LENGTH_CRC16_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_LENGTH_CRC16_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication
`define SLCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/slcr_pkg.sv]
`timescale 1ns / 1ps
package slcr_pkg;

  localparam logic [7:0]  SyncByte   = 8'hA5;
  localparam logic [15:0] CrcPoly    = 16'hA001;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcXorOut  = 16'hFFFF;
  localparam logic [15:0] MaxLenRst  = 16'd1030;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_CMD     = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC_HI  = 3'd5,
    PH_CRC_LO  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_BAD_CRC  = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  command;
    logic [7:0]  data_byte;
    logic [15:0] byte_offset;
    logic [15:0] frame_length;
  } res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/sync_length_crc16_frame_receiver.sv]
// sync/length framed byte receiver with crc-16/usb check
// input channel: rx_valid_i / rx_ready_o carry one received byte per item
// output channel: out_valid_o / out_ready_i carry at most one item per byte:
//   a payload byte with its offset, frame good, crc error or frame too long
// cfg_we_i writes cfg_wdata_i into the maximum payload length register
// a byte's result enters the output register once that register is free
// throughput: one byte per cycle unless the output stalls, set by the single
//   pass from the input register through the phase and crc logic into the
//   output register
// reset: hunting for the sync byte, crc preset, maximum length 1030,
//   both registers empty
// a stalled receiver holds the result; the input register still takes one
//   more byte, then ready drops until the result is taken
`timescale 1ns / 1ps
module sync_length_crc16_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  command_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_offset_o,
  output logic [15:0] frame_length_o
);
  import slcr_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        out_free;
  logic        fire;
  logic        res_valid;
  res_t        res;
  res_t        out_res;
  logic [15:0] max_len_q;

  assign fire = in_valid && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenRst;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  slcr_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_valid_i),
    .ready_o (rx_ready_o),
    .byte_i  (rx_byte_i),
    .take_i  (fire),
    .valid_o (in_valid),
    .byte_o  (in_byte)
  );

  slcr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  slcr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res)
  );

  assign out_kind_o     = out_res.kind;
  assign command_o      = out_res.command;
  assign data_byte_o    = out_res.data_byte;
  assign byte_offset_o  = out_res.byte_offset;
  assign frame_length_o = out_res.frame_length;

endmodule

[rtl/slcr_in_reg.sv]
`timescale 1ns / 1ps
module slcr_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);
  import slcr_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

endmodule

[rtl/slcr_core.sv]
`timescale 1ns / 1ps
`include "sync_length_crc16_frame_receiver_defines.svh"
module slcr_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [7:0]     byte_i,
  input  logic [15:0]    max_len_i,
  output logic           res_valid_o,
  output slcr_pkg::res_t res_o
);
  import slcr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;

  logic [15:0] crc_fed;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;

  assign crc_fed  = crc_feed(crc_q, byte_i);
  assign len_full = {len_q[15:8], byte_i};
  assign cnt_inc  = cnt_q + 16'd1;

  // next state
  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    crc_hi_d = crc_hi_q;
    unique case (phase_q)
      PH_CMD: begin
        cmd_d   = byte_i;
        crc_d   = crc_fed;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d   = {byte_i, 8'h00};
        crc_d   = crc_fed;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d = len_full;
        crc_d = crc_fed;
        cnt_d = '0;
        if (len_full > max_len_i) begin
          phase_d = PH_HUNT;
        end else if (len_full == '0) begin
          phase_d = PH_CRC_HI;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_d = crc_fed;
        cnt_d = cnt_inc;
        if (cnt_inc == len_q) begin
          phase_d = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        crc_hi_d = byte_i;
        phase_d  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        phase_d = PH_HUNT;
      end
      default: begin
        if (byte_i == SyncByte) begin
          crc_d   = CrcInit;
          phase_d = PH_CMD;
        end else begin
          phase_d = PH_HUNT;
        end
      end
    endcase
  end

  // result
  always_comb begin
    res_valid_o        = 1'b0;
    res_o.kind         = KIND_DATA;
    res_o.command      = cmd_q;
    res_o.data_byte    = '0;
    res_o.byte_offset  = '0;
    res_o.frame_length = len_q;
    unique case (phase_q)
      PH_LEN_LO: begin
        res_o.frame_length = len_full;
        if (len_full > max_len_i) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_TOO_LONG;
        end
      end
      PH_PAYLOAD: begin
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_DATA;
        res_o.data_byte   = byte_i;
        res_o.byte_offset = cnt_q;
      end
      PH_CRC_LO: begin
        res_valid_o = 1'b1;
        if ({crc_hi_q, byte_i} == (crc_q ^ CrcXorOut)) begin
          res_o.kind = KIND_GOOD;
        end else begin
          res_o.kind = KIND_BAD_CRC;
        end
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      cmd_q    <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      crc_q    <= CrcInit;
      crc_hi_q <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      crc_hi_q <= crc_hi_d;
    end
  end

  `SLCR_ASSERT_NOW(a_count_below_len, phase_q == PH_PAYLOAD, cnt_q < len_q,
                   "payload count reached declared length")
  `SLCR_ASSERT_NOW(a_offset_in_frame, res_valid_o && res_o.kind == KIND_DATA,
                   res_o.byte_offset < res_o.frame_length, "payload offset outside frame")
  `SLCR_ASSERT_NOW(a_status_clean, res_valid_o && res_o.kind != KIND_DATA,
                   res_o.data_byte == '0 && res_o.byte_offset == '0,
                   "status item carries payload fields")
  `SLCR_ASSERT_NEXT(a_status_hunts, fire_i && res_valid_o && res_o.kind != KIND_DATA,
                    phase_q == PH_HUNT, "no return to hunting after frame end")

endmodule

[rtl/slcr_out_reg.sv]
`timescale 1ns / 1ps
module slcr_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  slcr_pkg::res_t res_i,
  output logic           free_o,
  output logic           valid_o,
  input  logic           ready_i,
  output slcr_pkg::res_t res_o
);
  import slcr_pkg::*;

  logic valid_q;
  res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule
